[hw/rtl/stack_ir_to_riscv_translator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stack IR to RISC-V translator
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef STACK_IR_TO_RISCV_TRANSLATOR_ASSERT_SVH
`define STACK_IR_TO_RISCV_TRANSLATOR_ASSERT_SVH

// Same-cycle implication.
`define STIR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/stir_pkg.sv]
// ----------------------------------------------------------------------------
// stir_pkg
// Types, opcodes, register numbers and instruction encoders shared by the
// stack IR to RISC-V translator.
// ----------------------------------------------------------------------------
package stir_pkg;

    // IR opcodes.
    localparam logic [7:0] OP_NOP     = 8'd0;
    localparam logic [7:0] OP_ADD     = 8'd1;
    localparam logic [7:0] OP_SUB     = 8'd2;
    localparam logic [7:0] OP_MUL     = 8'd3;
    localparam logic [7:0] OP_DIV     = 8'd4;
    localparam logic [7:0] OP_LDCONST = 8'd5;
    localparam logic [7:0] OP_LDVAR   = 8'd6;
    localparam logic [7:0] OP_STVAR   = 8'd7;
    localparam logic [7:0] OP_CALL    = 8'd8;
    localparam logic [7:0] OP_RET     = 8'd9;

    // RISC-V major opcodes.
    localparam logic [6:0] OPC_IMM   = 7'b0010011;
    localparam logic [6:0] OPC_REG   = 7'b0110011;
    localparam logic [6:0] OPC_LOAD  = 7'b0000011;
    localparam logic [6:0] OPC_STORE = 7'b0100011;
    localparam logic [6:0] OPC_LUI   = 7'b0110111;
    localparam logic [6:0] OPC_JALR  = 7'b1100111;

    // Architectural registers.
    localparam logic [4:0] R_X0 = 5'd0;
    localparam logic [4:0] R_RA = 5'd1;
    localparam logic [4:0] R_SP = 5'd2;
    localparam logic [4:0] R_FP = 5'd8;
    localparam logic [4:0] R_A0 = 5'd10;
    localparam logic [4:0] R_A1 = 5'd11;
    localparam logic [4:0] R_A5 = 5'd15;

    // Function fields.
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_DIV = 3'd4;
    localparam logic [2:0] F3_D   = 3'd3;
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_SUB  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // Immediates used by the frame and stack sequences.
    localparam logic [11:0] IMM_ZERO  = 12'd0;
    localparam logic [11:0] IMM_P8    = 12'd8;
    localparam logic [11:0] IMM_P16   = 12'd16;
    localparam logic [11:0] IMM_M8    = 12'hFF8;
    localparam logic [11:0] IMM_M16   = 12'hFF0;
    localparam logic [31:0] CONST_BIAS = 32'h0000_0800;

    // Word counts.
    localparam int FRAME_WORDS = 4;
    localparam int MAX_WORDS   = 15;
    localparam int IDX_W       = 4;
    localparam int BODY_W      = 3;

    // Descriptor queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        K_NOP,
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_LDCONST,
        K_LDVAR,
        K_STVAR,
        K_CALL,
        K_RET
    } t_kind;

    // One classified IR item as handed from front to back.
    typedef struct packed {
        t_kind              kind;
        logic               pro;
        logic               epi;
        logic [11:0]        arg12;
        logic [19:0]        hi20;
        logic [BODY_W-1:0]  body_len;
        logic [IDX_W-1:0]   last_idx;
    } t_desc;

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] opc);
        enc_i = {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [6:0] opc);
        enc_s = {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
        enc_r = {f7, rs2, rs1, f3, rd, opc};
    endfunction

endpackage

[hw/rtl/stack_ir_to_riscv_translator.sv]
// ----------------------------------------------------------------------------
// stack_ir_to_riscv_translator
// Expands stack-machine IR operations into RV64 instruction words.
// ----------------------------------------------------------------------------
// Each accepted word on the input side is one IR operation; the block answers
// with the 1 to 15 RISC-V instruction words that implement it, in order, the
// final one of each item marked by o_last_word. The output side delivers one
// word per cycle while pop keeps the output register free. Item sizes in words:
// one for nop or an unknown opcode, three or four for a constant load,
// three for a variable load or store, five for call and return, seven for an
// arithmetic operation, plus four for a prologue and four for an epilogue.
// That word count at the single output register sets the sustained rate.
// Input words are classified at once and held in a four-entry descriptor
// queue, so new operations keep entering while earlier ones are still being
// emitted, and a stalled consumer only backs up the queue. From the queue an
// item goes to the current-descriptor register, then to the output register.
// The block keeps no state between items and needs no warm-up after reset.
// ----------------------------------------------------------------------------
module stack_ir_to_riscv_translator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_op,
    input  logic signed [31:0] i_arg,
    input  logic               i_start_of_function,
    input  logic               i_end_of_function,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        o_instr_word,
    output logic               o_last_word
);

    // Classified item as it enters the queue, and the queue head.
    stir_pkg::t_desc front_desc;
    stir_pkg::t_desc head_desc;
    logic            q_empty;
    logic            q_pop;

    // The front end decodes the opcode, splits a constant into its rounded
    // upper part and low twelve bits, and counts the words the item needs.
    stir_front u_front (
        .i_op                (i_op),
        .i_arg               (i_arg),
        .i_start_of_function (i_start_of_function),
        .i_end_of_function   (i_end_of_function),
        .o_desc              (front_desc)
    );

    // The queue accepts a new descriptor whenever it has room; full is the
    // only backpressure the input side sees.
    stir_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_desc (front_desc),
        .o_full    (full),
        .i_rd      (q_pop),
        .o_rd_desc (head_desc),
        .o_empty   (q_empty)
    );

    // The back end walks the current descriptor one word per cycle while the output
    // register is free, and takes the next descriptor in the same cycle it sends the
    // final word, so items follow one another with no gap on the output.
    stir_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_desc     (head_desc),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_instr_word (o_instr_word),
        .o_last_word  (o_last_word)
    );

endmodule

[hw/rtl/stir_front.sv]
// ----------------------------------------------------------------------------
// stir_front
// Classifies one IR item into a descriptor: operation kind, constant split
// and the number of words the item expands to.
// ----------------------------------------------------------------------------
module stir_front (
    input  logic [7:0]      i_op,
    input  logic signed [31:0] i_arg,
    input  logic            i_start_of_function,
    input  logic            i_end_of_function,
    output stir_pkg::t_desc o_desc
);

    stir_pkg::t_kind               kind;
    logic [31:0]                   biased;
    logic [19:0]                   hi20;
    logic [stir_pkg::BODY_W-1:0]   body_len;

    always_comb begin
        case (i_op)
            stir_pkg::OP_ADD:     kind = stir_pkg::K_ADD;
            stir_pkg::OP_SUB:     kind = stir_pkg::K_SUB;
            stir_pkg::OP_MUL:     kind = stir_pkg::K_MUL;
            stir_pkg::OP_DIV:     kind = stir_pkg::K_DIV;
            stir_pkg::OP_LDCONST: kind = stir_pkg::K_LDCONST;
            stir_pkg::OP_LDVAR:   kind = stir_pkg::K_LDVAR;
            stir_pkg::OP_STVAR:   kind = stir_pkg::K_STVAR;
            stir_pkg::OP_CALL:    kind = stir_pkg::K_CALL;
            stir_pkg::OP_RET:     kind = stir_pkg::K_RET;
            default:              kind = stir_pkg::K_NOP;
        endcase
    end

    // Rounded upper part of the constant; zero means it fits one ADDI.
    assign biased = $unsigned(i_arg) + stir_pkg::CONST_BIAS;
    assign hi20   = biased[31:12];

    always_comb begin
        case (kind)
            stir_pkg::K_ADD,
            stir_pkg::K_SUB,
            stir_pkg::K_MUL,
            stir_pkg::K_DIV:     body_len = stir_pkg::BODY_W'(7);
            stir_pkg::K_LDCONST: body_len = (hi20 == 20'd0) ? stir_pkg::BODY_W'(3)
                                                            : stir_pkg::BODY_W'(4);
            stir_pkg::K_LDVAR,
            stir_pkg::K_STVAR:   body_len = stir_pkg::BODY_W'(3);
            stir_pkg::K_CALL,
            stir_pkg::K_RET:     body_len = stir_pkg::BODY_W'(5);
            default:             body_len = stir_pkg::BODY_W'(1);
        endcase
    end

    always_comb begin
        o_desc.kind     = kind;
        o_desc.pro      = i_start_of_function;
        o_desc.epi      = i_end_of_function;
        o_desc.arg12    = i_arg[11:0];
        o_desc.hi20     = hi20;
        o_desc.body_len = body_len;
        o_desc.last_idx = stir_pkg::IDX_W'(body_len)
                        + (i_start_of_function ? stir_pkg::IDX_W'(stir_pkg::FRAME_WORDS)
                                               : stir_pkg::IDX_W'(0))
                        + (i_end_of_function ? stir_pkg::IDX_W'(stir_pkg::FRAME_WORDS)
                                             : stir_pkg::IDX_W'(0))
                        - stir_pkg::IDX_W'(1);
    end

endmodule

[hw/rtl/stir_queue.sv]
// ----------------------------------------------------------------------------
// stir_queue
// Short descriptor queue that decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
module stir_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  stir_pkg::t_desc i_wr_desc,
    output logic            o_full,
    input  logic            i_rd,
    output stir_pkg::t_desc o_rd_desc,
    output logic            o_empty
);

    stir_pkg::t_desc               r_mem [stir_pkg::Q_DEPTH];
    logic [stir_pkg::Q_AW-1:0]     r_wr_ptr;
    logic [stir_pkg::Q_AW-1:0]     r_rd_ptr;
    logic [stir_pkg::Q_CW-1:0]     r_count;
    logic [stir_pkg::Q_AW-1:0]     n_wr_ptr;
    logic [stir_pkg::Q_AW-1:0]     n_rd_ptr;
    logic [stir_pkg::Q_CW-1:0]     n_count;
    logic                          wr_en;
    logic                          rd_en;

    assign o_full  = (r_count == stir_pkg::Q_CW'(stir_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rd_desc = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == stir_pkg::Q_AW'(stir_pkg::Q_DEPTH - 1)) ? '0
                                                                            : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == stir_pkg::Q_AW'(stir_pkg::Q_DEPTH - 1)) ? '0
                                                                            : r_rd_ptr + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_desc;
        end
    end

endmodule

[hw/rtl/stir_back.sv]
// ----------------------------------------------------------------------------
// stir_back
// Walks one descriptor at a time, one instruction word per cycle while the
// output is free, into a single-entry output register.
// ----------------------------------------------------------------------------
`include "stack_ir_to_riscv_translator_assert.svh"

module stir_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stir_pkg::t_desc     i_q_desc,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [31:0]         o_instr_word,
    output logic                o_last_word
);

    logic                          r_cur_valid;
    stir_pkg::t_desc               r_desc;
    logic [stir_pkg::IDX_W-1:0]    r_idx;
    logic                          r_out_valid;
    logic [31:0]                   r_out_word;
    logic                          r_out_last;

    logic                          out_ready;
    logic                          emit;
    logic                          is_last;
    logic                          load;
    logic                          in_pro;
    logic                          in_epi;
    logic [stir_pkg::IDX_W-1:0]    bidx;
    logic [stir_pkg::IDX_W-1:0]    eidx;
    logic [stir_pkg::BODY_W-1:0]   cidx;
    logic [11:0]                   slot_off;
    logic [6:0]                    alu_f7;
    logic [2:0]                    alu_f3;
    logic [31:0]                   pro_word;
    logic [31:0]                   epi_word;
    logic [31:0]                   body_word;
    logic [31:0]                   word;
    logic [31:0]                   w_push_adj;
    logic [31:0]                   w_push_st;
    logic [31:0]                   w_pop_adj;

    assign out_ready = !r_out_valid || i_pop;
    assign emit      = r_cur_valid && out_ready;
    assign is_last   = (r_idx == r_desc.last_idx);
    assign load      = !r_cur_valid || (emit && is_last);
    assign o_q_pop   = load && !i_q_empty;

    // Position of the current word within prologue, body and epilogue.
    assign in_pro = r_desc.pro && (r_idx < stir_pkg::IDX_W'(stir_pkg::FRAME_WORDS));
    assign bidx   = r_idx - (r_desc.pro ? stir_pkg::IDX_W'(stir_pkg::FRAME_WORDS)
                                        : stir_pkg::IDX_W'(0));
    assign in_epi = !in_pro && (bidx >= stir_pkg::IDX_W'(r_desc.body_len));
    assign eidx   = bidx - stir_pkg::IDX_W'(r_desc.body_len);

    assign slot_off = {r_desc.arg12[8:0], 3'b000};
    // A small constant skips the LUI, so its body steps start one later.
    assign cidx = (r_desc.hi20 == 20'd0) ? bidx[stir_pkg::BODY_W-1:0] + 1'b1
                                         : bidx[stir_pkg::BODY_W-1:0];

    assign w_push_adj = stir_pkg::enc_i(stir_pkg::IMM_M8, stir_pkg::R_SP, stir_pkg::F3_ADD,
                                        stir_pkg::R_SP, stir_pkg::OPC_IMM);
    assign w_push_st  = stir_pkg::enc_s(stir_pkg::IMM_ZERO, stir_pkg::R_A0, stir_pkg::R_SP,
                                        stir_pkg::F3_D, stir_pkg::OPC_STORE);
    assign w_pop_adj  = stir_pkg::enc_i(stir_pkg::IMM_P8, stir_pkg::R_SP, stir_pkg::F3_ADD,
                                        stir_pkg::R_SP, stir_pkg::OPC_IMM);

    always_comb begin
        case (r_desc.kind)
            stir_pkg::K_SUB: begin
                alu_f7 = stir_pkg::F7_SUB;
                alu_f3 = stir_pkg::F3_ADD;
            end
            stir_pkg::K_MUL: begin
                alu_f7 = stir_pkg::F7_MULDIV;
                alu_f3 = stir_pkg::F3_ADD;
            end
            stir_pkg::K_DIV: begin
                alu_f7 = stir_pkg::F7_MULDIV;
                alu_f3 = stir_pkg::F3_DIV;
            end
            default: begin
                alu_f7 = stir_pkg::F7_BASE;
                alu_f3 = stir_pkg::F3_ADD;
            end
        endcase
    end

    always_comb begin
        case (r_idx[1:0])
            2'd0: pro_word = stir_pkg::enc_i(stir_pkg::IMM_M16, stir_pkg::R_SP,
                                             stir_pkg::F3_ADD, stir_pkg::R_SP,
                                             stir_pkg::OPC_IMM);
            2'd1: pro_word = stir_pkg::enc_s(stir_pkg::IMM_P8, stir_pkg::R_RA, stir_pkg::R_SP,
                                             stir_pkg::F3_D, stir_pkg::OPC_STORE);
            2'd2: pro_word = stir_pkg::enc_s(stir_pkg::IMM_ZERO, stir_pkg::R_FP,
                                             stir_pkg::R_SP, stir_pkg::F3_D,
                                             stir_pkg::OPC_STORE);
            default: pro_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_SP,
                                                stir_pkg::F3_ADD, stir_pkg::R_FP,
                                                stir_pkg::OPC_IMM);
        endcase
    end

    always_comb begin
        case (eidx[1:0])
            2'd0: epi_word = stir_pkg::enc_i(stir_pkg::IMM_P8, stir_pkg::R_FP, stir_pkg::F3_D,
                                             stir_pkg::R_RA, stir_pkg::OPC_LOAD);
            2'd1: epi_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_FP,
                                             stir_pkg::F3_D, stir_pkg::R_FP,
                                             stir_pkg::OPC_LOAD);
            2'd2: epi_word = stir_pkg::enc_i(stir_pkg::IMM_P16, stir_pkg::R_FP,
                                             stir_pkg::F3_ADD, stir_pkg::R_SP,
                                             stir_pkg::OPC_IMM);
            default: epi_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_RA,
                                                stir_pkg::F3_ADD, stir_pkg::R_X0,
                                                stir_pkg::OPC_JALR);
        endcase
    end

    always_comb begin
        body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_X0, stir_pkg::F3_ADD,
                                    stir_pkg::R_X0, stir_pkg::OPC_IMM);
        case (r_desc.kind)
            stir_pkg::K_ADD,
            stir_pkg::K_SUB,
            stir_pkg::K_MUL,
            stir_pkg::K_DIV: begin
                case (bidx[stir_pkg::BODY_W-1:0])
                    3'd0: body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_SP,
                                                      stir_pkg::F3_D, stir_pkg::R_A1,
                                                      stir_pkg::OPC_LOAD);
                    3'd1: body_word = w_pop_adj;
                    3'd2: body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_SP,
                                                      stir_pkg::F3_D, stir_pkg::R_A0,
                                                      stir_pkg::OPC_LOAD);
                    3'd3: body_word = w_pop_adj;
                    3'd4: body_word = stir_pkg::enc_r(alu_f7, stir_pkg::R_A1, stir_pkg::R_A0,
                                                      alu_f3, stir_pkg::R_A0,
                                                      stir_pkg::OPC_REG);
                    3'd5: body_word = w_push_adj;
                    default: body_word = w_push_st;
                endcase
            end
            stir_pkg::K_LDCONST: begin
                case (cidx)
                    3'd0: body_word = {r_desc.hi20, stir_pkg::R_A0, stir_pkg::OPC_LUI};
                    3'd1: body_word = stir_pkg::enc_i(r_desc.arg12,
                                                      (r_desc.hi20 == 20'd0) ? stir_pkg::R_X0
                                                                             : stir_pkg::R_A0,
                                                      stir_pkg::F3_ADD, stir_pkg::R_A0,
                                                      stir_pkg::OPC_IMM);
                    3'd2: body_word = w_push_adj;
                    default: body_word = w_push_st;
                endcase
            end
            stir_pkg::K_LDVAR: begin
                case (bidx[stir_pkg::BODY_W-1:0])
                    3'd0: body_word = stir_pkg::enc_i(slot_off, stir_pkg::R_FP, stir_pkg::F3_D,
                                                      stir_pkg::R_A0, stir_pkg::OPC_LOAD);
                    3'd1: body_word = w_push_adj;
                    default: body_word = w_push_st;
                endcase
            end
            stir_pkg::K_STVAR: begin
                case (bidx[stir_pkg::BODY_W-1:0])
                    3'd0: body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_SP,
                                                      stir_pkg::F3_D, stir_pkg::R_A0,
                                                      stir_pkg::OPC_LOAD);
                    3'd1: body_word = w_pop_adj;
                    default: body_word = stir_pkg::enc_s(slot_off, stir_pkg::R_A0,
                                                         stir_pkg::R_FP, stir_pkg::F3_D,
                                                         stir_pkg::OPC_STORE);
                endcase
            end
            stir_pkg::K_CALL: begin
                case (bidx[stir_pkg::BODY_W-1:0])
                    3'd0: body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_SP,
                                                      stir_pkg::F3_D, stir_pkg::R_A5,
                                                      stir_pkg::OPC_LOAD);
                    3'd1: body_word = w_pop_adj;
                    3'd2: body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_A5,
                                                      stir_pkg::F3_ADD, stir_pkg::R_RA,
                                                      stir_pkg::OPC_JALR);
                    3'd3: body_word = w_push_adj;
                    default: body_word = w_push_st;
                endcase
            end
            stir_pkg::K_RET: begin
                case (bidx[stir_pkg::BODY_W-1:0])
                    3'd0: body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_SP,
                                                      stir_pkg::F3_D, stir_pkg::R_A0,
                                                      stir_pkg::OPC_LOAD);
                    3'd1: body_word = w_pop_adj;
                    3'd2: body_word = stir_pkg::enc_i(stir_pkg::IMM_P8, stir_pkg::R_FP,
                                                      stir_pkg::F3_D, stir_pkg::R_RA,
                                                      stir_pkg::OPC_LOAD);
                    3'd3: body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_FP,
                                                      stir_pkg::F3_D, stir_pkg::R_FP,
                                                      stir_pkg::OPC_LOAD);
                    default: body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_RA,
                                                         stir_pkg::F3_ADD, stir_pkg::R_X0,
                                                         stir_pkg::OPC_JALR);
                endcase
            end
            default: begin
                body_word = stir_pkg::enc_i(stir_pkg::IMM_ZERO, stir_pkg::R_X0,
                                            stir_pkg::F3_ADD, stir_pkg::R_X0,
                                            stir_pkg::OPC_IMM);
            end
        endcase
    end

    assign word = in_pro ? pro_word : (in_epi ? epi_word : body_word);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_cur_valid <= !i_q_empty;
                r_idx       <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_desc <= i_q_desc;
        end
        if (emit) begin
            r_out_word <= word;
            r_out_last <= is_last;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_instr_word = r_out_word;
    assign o_last_word  = r_out_last;

    `STIR_ASSERT_IMPLY(a_idx_in_range, i_clk, i_rst_n, r_cur_valid, r_idx <= r_desc.last_idx, "word index past the item's last word")
    `STIR_ASSERT_NEXT(a_fetch_restarts, i_clk, i_rst_n, o_q_pop, r_cur_valid && (r_idx == '0), "fetched item did not start at its first word")
    `STIR_ASSERT_NEXT(a_last_marked, i_clk, i_rst_n, emit && is_last, r_out_valid && r_out_last, "final word of an item not marked")

endmodule

[tb/stack_ir_to_riscv_translator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_ir_to_riscv_translator_tb
// Self-checking bench for the stack IR to RISC-V translator. A short table
// of directed IR words is sent first, then random ones, about 150 IR words
// in all. Every accepted IR word is expanded by a local model, or taken from
// hand-typed words in the table, into the instruction words that should come
// out. Each popped word is checked against those expected words.
// ----------------------------------------------------------------------------
module stack_ir_to_riscv_translator_tb;

    // RV64 encoding fields, kept apart from the package so that the
    // expected words do not share constants with the design.
    localparam logic [6:0] RV_OPIMM = 7'h13;
    localparam logic [6:0] RV_OP    = 7'h33;
    localparam logic [6:0] RV_LOAD  = 7'h03;
    localparam logic [6:0] RV_SD    = 7'h23;
    localparam logic [6:0] RV_LUI   = 7'h37;
    localparam logic [6:0] RV_JALR  = 7'h67;

    localparam logic [4:0] X_ZERO = 5'd0;
    localparam logic [4:0] X_RA   = 5'd1;
    localparam logic [4:0] X_SP   = 5'd2;
    localparam logic [4:0] X_FP   = 5'd8;
    localparam logic [4:0] X_A0   = 5'd10;
    localparam logic [4:0] X_A1   = 5'd11;
    localparam logic [4:0] X_A5   = 5'd15;

    localparam logic [2:0] FN_ADD    = 3'd0;
    localparam logic [2:0] FN_DOUBLE = 3'd3;
    localparam logic [2:0] FN_DIV    = 3'd4;

    localparam logic [6:0] FN7_BASE   = 7'h00;
    localparam logic [6:0] FN7_SUB    = 7'h20;
    localparam logic [6:0] FN7_MULDIV = 7'h01;

    localparam logic [31:0] NOP_WORD = 32'h0000_0013;

    localparam int RAND_ITEMS   = 126;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_DIRECTED = 24;

    // One IR word of stimulus. Where n_known is nonzero, the first n_known
    // of known0..known2 are the full expected output, typed in by hand.
    typedef struct packed {
        logic [7:0]  op;
        logic [31:0] arg;
        logic        sof;
        logic        eof;
        logic [1:0]  n_known;
        logic [31:0] known0;
        logic [31:0] known1;
        logic [31:0] known2;
    } t_ir_row;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_rv_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_op;
    logic signed [31:0] i_arg;
    logic               i_start_of_function;
    logic               i_end_of_function;
    logic               empty;
    logic               pop;
    logic [31:0]        o_instr_word;
    logic               o_last_word;

    // Expected instruction words, oldest first, with their last marks.
    t_rv_word    pending_words[$];
    // Scratch list that the model fills for one IR word.
    logic [31:0] word_seq[$];

    int send_gap_pct = 9;
    int recv_gap_pct = 61;
    int fail_count   = 0;
    logic stall_start = 1'b0;
    logic rx_hold;

    // Directed table: extremes of every field, every opcode, unknown
    // opcodes, constants on both sides of the 12-bit boundary, the top of
    // the 32-bit range where the LUI rounding wraps, slot indexes whose
    // byte offset wraps, and items with prologue, epilogue or both.
    t_ir_row directed_rows [NUM_DIRECTED] = '{
        '{stir_pkg::OP_NOP,     32'h0000_0000, 1'b0, 1'b0, 2'd1, NOP_WORD, 32'h0, 32'h0},
        '{8'd10,                32'h0000_0000, 1'b0, 1'b0, 2'd1, NOP_WORD, 32'h0, 32'h0},
        '{8'd255,               32'hFFFF_FFFF, 1'b0, 1'b0, 2'd1, NOP_WORD, 32'h0, 32'h0},
        '{stir_pkg::OP_LDCONST, 32'h0000_0000, 1'b0, 1'b0, 2'd3,
          32'h0000_0513, 32'hFF81_0113, 32'h00A1_3023},
        '{stir_pkg::OP_LDCONST, 32'h0000_07FF, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_LDCONST, 32'hFFFF_F800, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_LDCONST, 32'h0000_0800, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_LDCONST, 32'hFFFF_F7FF, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_LDCONST, 32'h7FFF_FFFF, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_LDCONST, 32'h8000_0000, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_LDCONST, 32'h7FFF_F800, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_ADD,     32'h0000_0000, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_SUB,     32'h1234_5678, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_MUL,     32'h0000_0000, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_DIV,     32'h0000_0000, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_LDVAR,   32'h0000_0000, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_LDVAR,   32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_STVAR,   32'h0000_01FF, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_STVAR,   32'h8000_0000, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_CALL,    32'h0000_0000, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_RET,     32'h0000_0000, 1'b0, 1'b1, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_ADD,     32'h0000_0000, 1'b1, 1'b1, 2'd0, 32'h0, 32'h0, 32'h0},
        '{stir_pkg::OP_NOP,     32'h0000_0000, 1'b1, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0},
        '{8'hAA,                32'h5555_5555, 1'b0, 1'b1, 2'd0, 32'h0, 32'h0, 32'h0}
    };

    stack_ir_to_riscv_translator i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_op                (i_op),
        .i_arg               (i_arg),
        .i_start_of_function (i_start_of_function),
        .i_end_of_function   (i_end_of_function),
        .empty               (empty),
        .pop                 (pop),
        .o_instr_word        (o_instr_word),
        .o_last_word         (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Instruction formats.
    // ------------------------------------------------------------------
    function automatic logic [31:0] fmt_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] fmt_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [6:0] opc);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
    endfunction

    // Appends one instruction word to the scratch list.
    task automatic queue_word(input logic [31:0] w);
        word_seq.insert(word_seq.size(), w);
    endtask

    // Push a0 onto the memory stack: addi sp,sp,-8 then sd a0,0(sp).
    task automatic emit_push_a0();
        queue_word(fmt_i(12'hFF8, X_SP, FN_ADD, X_SP, RV_OPIMM));
        queue_word(fmt_s(12'd0, X_A0, X_SP, FN_DOUBLE, RV_SD));
    endtask

    // Pop the top of the stack into rd: ld rd,0(sp) then addi sp,sp,8.
    task automatic emit_pop_to(input logic [4:0] rd);
        queue_word(fmt_i(12'd0, X_SP, FN_DOUBLE, rd, RV_LOAD));
        queue_word(fmt_i(12'd8, X_SP, FN_ADD, X_SP, RV_OPIMM));
    endtask

    // Expands one IR word into the instruction words it should produce.
    task automatic translate_ir(input t_ir_row it);
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [31:0] biased;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] offset;

        offset = it.arg << 3;
        if (it.sof) begin
            queue_word(fmt_i(12'hFF0, X_SP, FN_ADD, X_SP, RV_OPIMM));
            queue_word(fmt_s(12'd8, X_RA, X_SP, FN_DOUBLE, RV_SD));
            queue_word(fmt_s(12'd0, X_FP, X_SP, FN_DOUBLE, RV_SD));
            queue_word(fmt_i(12'd0, X_SP, FN_ADD, X_FP, RV_OPIMM));
        end

        case (it.op)
            stir_pkg::OP_ADD, stir_pkg::OP_SUB, stir_pkg::OP_MUL, stir_pkg::OP_DIV: begin
                if (it.op == stir_pkg::OP_ADD)
                    f7 = FN7_BASE;
                else if (it.op == stir_pkg::OP_SUB)
                    f7 = FN7_SUB;
                else
                    f7 = FN7_MULDIV;
                f3 = (it.op == stir_pkg::OP_DIV) ? FN_DIV : FN_ADD;
                emit_pop_to(X_A1);
                emit_pop_to(X_A0);
                queue_word({f7, X_A1, X_A0, f3, X_A0, RV_OP});
                emit_push_a0();
            end
            stir_pkg::OP_LDCONST: begin
                // Constants that fit a signed 12-bit immediate take one addi;
                // the rest a rounded lui plus an addi of the remainder.
                biased = it.arg + 32'h800;
                if (biased < 32'h1000) begin
                    queue_word(fmt_i(it.arg[11:0], X_ZERO, FN_ADD, X_A0, RV_OPIMM));
                end else begin
                    hi = biased & 32'hFFFF_F000;
                    lo = it.arg - hi;
                    queue_word({hi[31:12], X_A0, RV_LUI});
                    queue_word(fmt_i(lo[11:0], X_A0, FN_ADD, X_A0, RV_OPIMM));
                end
                emit_push_a0();
            end
            stir_pkg::OP_LDVAR: begin
                queue_word(fmt_i(offset[11:0], X_FP, FN_DOUBLE, X_A0, RV_LOAD));
                emit_push_a0();
            end
            stir_pkg::OP_STVAR: begin
                emit_pop_to(X_A0);
                queue_word(fmt_s(offset[11:0], X_A0, X_FP, FN_DOUBLE, RV_SD));
            end
            stir_pkg::OP_CALL: begin
                emit_pop_to(X_A5);
                queue_word(fmt_i(12'd0, X_A5, FN_ADD, X_RA, RV_JALR));
                emit_push_a0();
            end
            stir_pkg::OP_RET: begin
                emit_pop_to(X_A0);
                queue_word(fmt_i(12'd8, X_FP, FN_DOUBLE, X_RA, RV_LOAD));
                queue_word(fmt_i(12'd0, X_FP, FN_DOUBLE, X_FP, RV_LOAD));
                queue_word(fmt_i(12'd0, X_RA, FN_ADD, X_ZERO, RV_JALR));
            end
            default: begin
                // Nop and every unknown opcode give a single addi x0,x0,0.
                queue_word(NOP_WORD);
            end
        endcase

        if (it.eof) begin
            queue_word(fmt_i(12'd8, X_FP, FN_DOUBLE, X_RA, RV_LOAD));
            queue_word(fmt_i(12'd0, X_FP, FN_DOUBLE, X_FP, RV_LOAD));
            queue_word(fmt_i(12'd16, X_FP, FN_ADD, X_SP, RV_OPIMM));
            queue_word(fmt_i(12'd0, X_RA, FN_ADD, X_ZERO, RV_JALR));
        end
    endtask

    // Offers one IR word, waits until it is taken, then files its expected
    // instruction words. The first result still has to pass the queue and the
    // back end's registers, so filing after the accepting edge is early enough.
    task automatic send_row(input t_ir_row it);
        t_rv_word entry;

        while ($urandom_range(0, 99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push                <= 1'b1;
        i_op                <= it.op;
        i_arg               <= it.arg;
        i_start_of_function <= it.sof;
        i_end_of_function   <= it.eof;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);

        word_seq.delete();
        if (it.n_known != 2'd0) begin
            queue_word(it.known0);
            if (it.n_known > 2'd1)
                queue_word(it.known1);
            if (it.n_known > 2'd2)
                queue_word(it.known2);
        end else begin
            translate_ir(it);
        end
        foreach (word_seq[k]) begin
            entry.word = word_seq[k];
            entry.last = (k == word_seq.size() - 1);
            pending_words.insert(pending_words.size(), entry);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, the directed table, then three random phases with
    // different idling, the last one also carrying the long output stall.
    // ------------------------------------------------------------------
    initial begin
        t_ir_row row;

        i_rst_n             <= 1'b0;
        push                <= 1'b0;
        i_op                <= 8'd0;
        i_arg               <= 32'sd0;
        i_start_of_function <= 1'b0;
        i_end_of_function   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_row(directed_rows[r]);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3) begin
                send_gap_pct = 61;
                recv_gap_pct = 9;
            end else if (n == 2 * RAND_ITEMS / 3) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
                stall_start  = 1'b1;
            end

            row = '0;
            if ($urandom_range(0, 99) < 88)
                row.op = 8'($urandom_range(0, 9));
            else
                row.op = 8'($urandom_range(10, 255));

            // Mix of short constants, full-range values, small slot
            // indexes and values around the 12-bit and 32-bit edges.
            case ($urandom_range(0, 3))
                0: row.arg = 32'($urandom_range(0, 4095)) - 32'd2048;
                1: row.arg = $urandom;
                2: row.arg = 32'($urandom_range(0, 511));
                default: begin
                    row.arg       = $urandom_range(0, 1) ? 32'h7FFF_F000 : 32'hFFFF_F000;
                    row.arg[11:0] = 12'($urandom_range(0, 4095));
                end
            endcase
            row.sof = ($urandom_range(0, 3) == 0);
            row.eof = ($urandom_range(0, 3) == 0);
            send_row(row);
        end
        push <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge i_clk);
        // Keep clocking for DRAIN_CYCLES so that any stray word still gets caught.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Long output stall: once the last random phase starts, pop stays low
    // for a fixed stretch while the sender keeps offering, so the
    // descriptor queue fills and full must hold the input back.
    initial begin
        rx_hold <= 1'b0;
        wait (stall_start);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Output side: checks every popped word against the oldest expected
    // one, then decides pop for the next edge.
    initial begin
        t_rv_word want;

        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (pending_words.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: word %h last %b popped with nothing pending",
                                 $realtime, o_instr_word, o_last_word);
                    fail_count++;
                end else begin
                    want = pending_words.pop_front();
                    if (o_instr_word !== want.word || o_last_word !== want.last) begin
                        if (fail_count < 10)
                            $display("%0t: expected word %h last %b, got word %h last %b",
                                     $realtime, want.word, want.last,
                                     o_instr_word, o_last_word);
                        fail_count++;
                    end
                end
            end
            if (!i_rst_n || rx_hold)
                pop <= 1'b0;
            else
                pop <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

endmodule
